// ----- rtl/sorted_priority_queue_defines.svh -----
// Assertion helpers for the RTL file that checks its own logic.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// Next-cycle implication, sampled on i_clk, off while reset is low
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

// ----- rtl/spq_pkg.sv -----
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 16;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_SERVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    // per-cell control from the top level; push and pop go to every cell
    typedef struct packed {
        logic push;   // accepted push, queue not full
        logic pop;    // accepted serve, queue not empty
        logic occ;    // cell holds a live entry
        logic head;   // cell is the head of the row
    } t_cell_ctl;

endpackage

// ----- rtl/spq_in_if.sv -----
interface spq_in_if
    import spq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [ID_W-1:0]          entry_id;
    logic signed [PRIO_W-1:0] entry_priority;

    modport source (output valid, output opcode, output entry_id,
                    output entry_priority, input ready);
    modport sink   (input valid, input opcode, input entry_id,
                    input entry_priority, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
interface spq_out_if
    import spq_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    logic [ID_W-1:0] served_id;

    modport source (output valid, output status, output served_id, input ready);
    modport sink   (input valid, input status, input served_id, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_prev,
    input  t_entry    i_next,
    input  logic      i_left_stay,
    output t_entry    o_entry,
    output logic      o_stay
);

    t_entry r_entry;
    t_entry n_entry;

    // a live entry holds its place on a push of lower priority; the head keeps it on a tie too
    always_comb begin
        if (i_ctl.head) begin
            o_stay = i_ctl.occ && ($signed(i_new.prio) <= $signed(r_entry.prio));
        end else begin
            o_stay = i_ctl.occ && ($signed(i_new.prio) < $signed(r_entry.prio));
        end
    end

    // keep, take the new word, shift from the left on push, from the right on pop
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop) begin
            n_entry = i_next;
        end else if (i_ctl.push && !o_stay) begin
            if (i_left_stay) begin
                n_entry = i_new;
            end else begin
                n_entry = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Channel  Dir  Words carried
// i_in     in   opcode, entry_id, entry_priority
// o_out    out  status, served_id
//
// For each word every cell compares the new priority at once and
// keeps, loads or shifts its entry from a neighbor in the same edge.
// Result appears the cycle after accept, held in an output register.
// A new word is accepted while the output register is empty or being taken.
// Reset (i_rst_n low, synchronous) empties the queue and the output register.
`include "sorted_priority_queue_defines.svh"
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    spq_in_if.sink   i_in,
    spq_out_if.source o_out
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    logic [ID_W-1:0]  r_served_id;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    logic      push_ok;
    logic      pop_ok;
    t_entry    new_entry;
    t_entry    cell_q   [CAPACITY];
    logic      cell_stay[CAPACITY];
    t_cell_ctl cell_ctl [CAPACITY];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_full    = (r_count == CNT_W'(CAPACITY));
    assign is_empty   = (r_count == '0);
    assign push_ok    = accept && (i_in.opcode == OP_PUSH) && !is_full;
    assign pop_ok     = accept && (i_in.opcode == OP_SERVE) && !is_empty;
    assign new_entry  = '{id: i_in.entry_id, prio: i_in.entry_priority};

    // row of cells, head at index 0
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_entry prev_q;
        t_entry next_q;
        logic   left_stay;

        assign cell_ctl[k] = '{push: push_ok, pop: pop_ok,
                               occ: (CNT_W'(k) < r_count), head: (k == 0)};

        if (k == 0) begin : g_head
            assign prev_q    = new_entry;
            assign left_stay = 1'b1;
        end else begin : g_body
            assign prev_q    = cell_q[k-1];
            assign left_stay = cell_stay[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign next_q = '0;
        end else begin : g_inner
            assign next_q = cell_q[k+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[k]),
            .i_new       (new_entry),
            .i_prev      (prev_q),
            .i_next      (next_q),
            .i_left_stay (left_stay),
            .o_entry     (cell_q[k]),
            .o_stay      (cell_stay[k])
        );
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_served_id <= '0;
            if (i_in.opcode == OP_SERVE) begin
                if (is_empty) begin
                    r_status <= ST_EMPTY;
                end else begin
                    r_status    <= ST_SERVED;
                    r_served_id <= cell_q[0].id;
                end
            end else if (is_full) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_PUSHED;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.served_id = r_served_id;

    // checks
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_push_grows, push_ok, r_count == $past(r_count) + CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_empty_serve,
        accept && (i_in.opcode == OP_SERVE) && is_empty,
        (r_status == ST_EMPTY) && (r_count == '0))
    `SPQ_ASSERT_NOW(a_head_sorted, cell_ctl[1].occ,
        $signed(cell_q[0].prio) >= $signed(cell_q[1].prio))

endmodule
